FILE: rtl/core/dtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_pkg: shared types and constants of the delayed task dispatcher
// Operation and status codes, entry layouts and the control and status
// bundles that pass between the dispatcher's sequencer and its two stores.
// ----------------------------------------------------------------------------
package dtd_pkg;

    localparam int HANDLE_W = 16;
    localparam int SEQ_W    = 32;
    localparam int TIME_W   = 48;
    localparam int DELAY_W  = 32;

    localparam int IMMEDIATE_DEPTH_DEF = 16;
    localparam int DELAYED_DEPTH_DEF   = 16;

    typedef enum logic [1:0] {
        OP_ADD_IMM = 2'd0,
        OP_ADD_DLY = 2'd1,
        OP_FETCH   = 2'd2,
        OP_STOP    = 2'd3
    } dtd_op_t;

    typedef enum logic [2:0] {
        ST_DISPATCHED = 3'd0,
        ST_TIMED      = 3'd1,
        ST_FOREVER    = 3'd2,
        ST_STOPPED    = 3'd3,
        ST_ACCEPTED   = 3'd4,
        ST_FULL       = 3'd5
    } dtd_status_t;

    // One entry of the immediate FIFO.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
    } dtd_fifo_entry_t;

    // One entry of the delayed set.
    typedef struct packed {
        logic [TIME_W-1:0]   expiry;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
    } dtd_dly_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd_head;
    } dtd_fifo_cmd_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } dtd_fifo_stat_t;

    typedef struct packed {
        logic start_free;
        logic start_scan;
        logic clear_best;
    } dtd_dly_cmd_t;

    typedef struct packed {
        logic done;
        logic free_ok;
        logic best_found;
    } dtd_dly_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/dtd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/dtd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_fifo: immediate task FIFO
// Circular buffer in a RAM with head pointer and fill count.
// ----------------------------------------------------------------------------
module dtd_fifo #(
    parameter int DEPTH = dtd_pkg::IMMEDIATE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dtd_pkg::dtd_fifo_cmd_t   cmd,
    input  wire dtd_pkg::dtd_fifo_entry_t push_entry,
    output dtd_pkg::dtd_fifo_stat_t       stat,
    output dtd_pkg::dtd_fifo_entry_t      head_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic [$bits(dtd_pkg::dtd_fifo_entry_t)-1:0] rd_data;

    assign tail_sum = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : AW'(tail_sum);

    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.nonempty = (count_reg != '0);
    assign head_entry    = dtd_pkg::dtd_fifo_entry_t'(rd_data);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    dtd_ram #(
        .WIDTH ($bits(dtd_pkg::dtd_fifo_entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail),
        .wr_data (push_entry),
        .rd_en   (cmd.rd_head),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/dtd_delayed.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_delayed: delayed task set
// Entries live in a RAM with a valid bit per slot in flops. A free-slot
// search and a minimum scan each walk the slots one per cycle.
// ----------------------------------------------------------------------------
module dtd_delayed #(
    parameter int DEPTH = dtd_pkg::DELAYED_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dtd_pkg::dtd_dly_cmd_t   cmd,
    input  wire dtd_pkg::dtd_dly_entry_t new_entry,
    output dtd_pkg::dtd_dly_stat_t       stat,
    output dtd_pkg::dtd_dly_entry_t      best_entry
);

    localparam int IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        P_IDLE,
        P_FREE,
        P_SCAN
    } phase_t;

    phase_t                  phase_reg;
    logic [IW-1:0]           idx_reg;
    logic [DEPTH-1:0]        valid_reg;
    logic                    done_reg;
    logic                    free_ok_reg;
    logic                    best_found_reg;
    logic [IW-1:0]           best_idx_reg;
    dtd_pkg::dtd_dly_entry_t best_reg;

    logic                    last;
    logic                    slot_free;
    logic                    wr_en;
    logic                    rd_en;
    logic [IW-1:0]           rd_addr;
    logic                    take;
    dtd_pkg::dtd_dly_entry_t rd_ent;
    logic [$bits(dtd_pkg::dtd_dly_entry_t)-1:0] rd_data;

    assign rd_ent    = dtd_pkg::dtd_dly_entry_t'(rd_data);
    assign last      = (idx_reg == IW'(DEPTH - 1));
    assign slot_free = !valid_reg[idx_reg];
    assign wr_en     = (phase_reg == P_FREE) && slot_free;
    assign rd_en     = cmd.start_scan || (phase_reg == P_SCAN && !last);
    assign rd_addr   = cmd.start_scan ? '0 : idx_reg + IW'(1);

    // Strictly smaller wins, so among equal keys the lowest slot stays.
    assign take = valid_reg[idx_reg] &&
                  (!best_found_reg ||
                   rd_ent.expiry < best_reg.expiry ||
                   (rd_ent.expiry == best_reg.expiry && rd_ent.seq < best_reg.seq));

    assign stat.done       = done_reg;
    assign stat.free_ok    = free_ok_reg;
    assign stat.best_found = best_found_reg;
    assign best_entry      = best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            free_ok_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_reg       <= '0;
        end
        else
        begin
            // Done pulses once, in the cycle after a search or scan ends.
            done_reg <= ((phase_reg == P_FREE) && (slot_free || last)) ||
                        ((phase_reg == P_SCAN) && last);
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (cmd.start_free)
                    begin
                        idx_reg   <= '0;
                        phase_reg <= P_FREE;
                    end
                    else if (cmd.start_scan)
                    begin
                        idx_reg        <= '0;
                        best_found_reg <= 1'b0;
                        phase_reg      <= P_SCAN;
                    end
                    else if (cmd.clear_best)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
                P_FREE:
                begin
                    if (slot_free)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        free_ok_reg        <= 1'b1;
                        phase_reg          <= P_IDLE;
                    end
                    else if (last)
                    begin
                        free_ok_reg <= 1'b0;
                        phase_reg   <= P_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                P_SCAN:
                begin
                    if (take)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= idx_reg;
                        best_reg       <= rd_ent;
                    end
                    if (last)
                    begin
                        phase_reg <= P_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    dtd_ram #(
        .WIDTH ($bits(dtd_pkg::dtd_dly_entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (new_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/delayed_task_dispatcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delayed_task_dispatcher: two-store task dispatcher
// Immediate tasks queue in a FIFO, delayed tasks in a set keyed by expiry
// and sequence number. A fetch dispatches the FIFO head or the earliest due
// delayed task, whichever is older, or reports how long to sleep.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Fields
//  -------  -------------------  ---------------------------------------------
//  input    in_valid / in_stall  operation, task_handle, delay_ms, now_ms
//  output   out_valid/out_stall  status, out_handle, sleep_ms
//
// One word is worked on at a time. Add immediate, stop and a fetch after
// stop go from the execute state straight to the finish state. A fetch
// waits in the wait state for the minimum scan, which reads one slot of
// the delayed-set RAM per cycle; add delayed waits there while its free-slot
// search walks the valid bits.
// Reset is asynchronous and active low; it empties both stores at once, since
// the delayed set keeps a valid bit per slot and the FIFO a fill count.
// A new word is accepted while the previous result still waits in the
// output register; only loading the next result waits for a stall to clear.
//
module delayed_task_dispatcher #(
    parameter int IMMEDIATE_DEPTH = dtd_pkg::IMMEDIATE_DEPTH_DEF,
    parameter int DELAYED_DEPTH   = dtd_pkg::DELAYED_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   operation,
    input  wire logic [dtd_pkg::HANDLE_W-1:0] task_handle,
    input  wire logic [dtd_pkg::DELAY_W-1:0]  delay_ms,
    input  wire logic [dtd_pkg::TIME_W-1:0]   now_ms,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [2:0]                        status,
    output logic [dtd_pkg::HANDLE_W-1:0]      out_handle,
    output logic [dtd_pkg::TIME_W-1:0]        sleep_ms
);

    localparam int TW = dtd_pkg::TIME_W;
    localparam int SW = dtd_pkg::SEQ_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t                       state_reg;

    // Word being worked on.
    dtd_pkg::dtd_op_t             op_reg;
    logic [dtd_pkg::HANDLE_W-1:0] handle_reg;
    logic [dtd_pkg::DELAY_W-1:0]  delay_reg;
    logic [TW-1:0]                now_reg;

    logic [SW-1:0]                seq_reg;
    logic                         stopped_reg;

    // Result waiting to be loaded into the output register.
    dtd_pkg::dtd_status_t         res_status_reg;
    logic [dtd_pkg::HANDLE_W-1:0] res_handle_reg;
    logic [TW-1:0]                res_sleep_reg;

    logic                         out_valid_reg;
    dtd_pkg::dtd_status_t         out_status_reg;
    logic [dtd_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [TW-1:0]                out_sleep_reg;

    dtd_pkg::dtd_fifo_cmd_t       fifo_cmd;
    dtd_pkg::dtd_fifo_stat_t      fifo_stat;
    dtd_pkg::dtd_fifo_entry_t     fifo_push;
    dtd_pkg::dtd_fifo_entry_t     fifo_head;
    dtd_pkg::dtd_dly_cmd_t        dly_cmd;
    dtd_pkg::dtd_dly_stat_t       dly_stat;
    dtd_pkg::dtd_dly_entry_t      dly_new;
    dtd_pkg::dtd_dly_entry_t      dly_best;

    logic                         in_accept;
    logic                         out_free;
    logic [TW:0]                  expiry_sum;
    logic                         expired;
    logic                         head_first;
    logic                         pick_dly;
    logic                         fetch_done;
    logic                         add_dly_done;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign out_handle = out_handle_reg;
    assign sleep_ms   = out_sleep_reg;

    // Expiry saturates at the largest timestamp.
    assign expiry_sum = (TW+1)'(now_reg) + (TW+1)'(delay_reg);

    assign fifo_push.handle = handle_reg;
    assign fifo_push.seq    = seq_reg;
    assign dly_new.expiry   = expiry_sum[TW] ? {TW{1'b1}} : expiry_sum[TW-1:0];
    assign dly_new.handle   = handle_reg;
    assign dly_new.seq      = seq_reg;

    // Fetch decision, taken in the cycle that the scan reports done. The
    // FIFO head goes first when no delayed task is due, or when it is older
    // than the earliest due delayed task.
    assign expired      = dly_stat.best_found && (now_reg >= dly_best.expiry);
    assign head_first   = fifo_stat.nonempty && (!expired || fifo_head.seq < dly_best.seq);
    assign pick_dly     = expired && !head_first;
    assign fetch_done   = (state_reg == S_WAIT) && dly_stat.done && (op_reg == dtd_pkg::OP_FETCH);
    assign add_dly_done = (state_reg == S_WAIT) && dly_stat.done &&
                          (op_reg == dtd_pkg::OP_ADD_DLY);

    always_comb
    begin
        fifo_cmd.push    = (state_reg == S_EXEC) && (op_reg == dtd_pkg::OP_ADD_IMM) &&
                           !fifo_stat.full;
        fifo_cmd.pop     = fetch_done && head_first;
        fifo_cmd.rd_head = (state_reg == S_EXEC) && (op_reg == dtd_pkg::OP_FETCH) &&
                           !stopped_reg;

        dly_cmd.start_free = (state_reg == S_EXEC) && (op_reg == dtd_pkg::OP_ADD_DLY);
        dly_cmd.start_scan = fifo_cmd.rd_head;
        dly_cmd.clear_best = fetch_done && pick_dly;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= dtd_pkg::OP_ADD_IMM;
            handle_reg     <= '0;
            delay_reg      <= '0;
            now_reg        <= '0;
            seq_reg        <= '0;
            stopped_reg    <= 1'b0;
            res_status_reg <= dtd_pkg::ST_ACCEPTED;
            res_handle_reg <= '0;
            res_sleep_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= dtd_pkg::ST_ACCEPTED;
            out_handle_reg <= '0;
            out_sleep_reg  <= '0;
        end
        else
        begin
            // In the finish state a draining word is replaced by the new one.
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg     <= dtd_pkg::dtd_op_t'(operation);
                        handle_reg <= task_handle;
                        delay_reg  <= delay_ms;
                        now_reg    <= now_ms;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_handle_reg <= '0;
                    res_sleep_reg  <= '0;
                    unique case (op_reg)
                        dtd_pkg::OP_ADD_IMM:
                        begin
                            if (fifo_stat.full)
                            begin
                                res_status_reg <= dtd_pkg::ST_FULL;
                            end
                            else
                            begin
                                seq_reg        <= seq_reg + SW'(1);
                                res_status_reg <= dtd_pkg::ST_ACCEPTED;
                            end
                            state_reg <= S_FINISH;
                        end
                        dtd_pkg::OP_ADD_DLY:
                        begin
                            state_reg <= S_WAIT;
                        end
                        dtd_pkg::OP_STOP:
                        begin
                            stopped_reg    <= 1'b1;
                            res_status_reg <= dtd_pkg::ST_STOPPED;
                            state_reg      <= S_FINISH;
                        end
                        dtd_pkg::OP_FETCH:
                        begin
                            if (stopped_reg)
                            begin
                                res_status_reg <= dtd_pkg::ST_STOPPED;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_WAIT;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    if (add_dly_done)
                    begin
                        if (dly_stat.free_ok)
                        begin
                            seq_reg        <= seq_reg + SW'(1);
                            res_status_reg <= dtd_pkg::ST_ACCEPTED;
                        end
                        else
                        begin
                            res_status_reg <= dtd_pkg::ST_FULL;
                        end
                        state_reg <= S_FINISH;
                    end
                    else if (fetch_done)
                    begin
                        if (head_first)
                        begin
                            res_status_reg <= dtd_pkg::ST_DISPATCHED;
                            res_handle_reg <= fifo_head.handle;
                        end
                        else if (pick_dly)
                        begin
                            res_status_reg <= dtd_pkg::ST_DISPATCHED;
                            res_handle_reg <= dly_best.handle;
                        end
                        else if (dly_stat.best_found)
                        begin
                            res_status_reg <= dtd_pkg::ST_TIMED;
                            res_sleep_reg  <= dly_best.expiry - now_reg;
                        end
                        else
                        begin
                            res_status_reg <= dtd_pkg::ST_FOREVER;
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // Load only when the output register is empty or drains now.
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_handle_reg <= res_handle_reg;
                        out_sleep_reg  <= res_sleep_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    dtd_fifo #(
        .DEPTH (IMMEDIATE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (fifo_cmd),
        .push_entry (fifo_push),
        .stat       (fifo_stat),
        .head_entry (fifo_head)
    );

    dtd_delayed #(
        .DEPTH (DELAYED_DEPTH)
    ) u_delayed (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dly_cmd),
        .new_entry  (dly_new),
        .stat       (dly_stat),
        .best_entry (dly_best)
    );

endmodule
`default_nettype wire

FILE: dv/tb_delayed_task_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delayed_task_dispatcher: self-checking bench of the task dispatcher
// Drives add, fetch and stop words through the valid/stall input channel and
// predicts every answer. A scoreboard class keeps its own copy of both
// stores and checks each answer word against the oldest prediction.
// ----------------------------------------------------------------------------

import dtd_pkg::*;

typedef struct {
    dtd_status_t         status;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   sleep;
} dispatch_answer_t;

class dispatch_scoreboard;

    logic [HANDLE_W-1:0] fifo_handle [IMMEDIATE_DEPTH_DEF];
    logic [SEQ_W-1:0]    fifo_seq    [IMMEDIATE_DEPTH_DEF];
    int unsigned         fifo_head;
    int unsigned         fifo_count;
    logic [TIME_W-1:0]   dly_expiry  [DELAYED_DEPTH_DEF];
    logic [HANDLE_W-1:0] dly_handle  [DELAYED_DEPTH_DEF];
    logic [SEQ_W-1:0]    dly_seq     [DELAYED_DEPTH_DEF];
    bit                  dly_valid   [DELAYED_DEPTH_DEF];
    logic [SEQ_W-1:0]    next_seq;
    bit                  is_stopped;
    dispatch_answer_t    answers_due [$];
    int                  errors;

    function new();
        fifo_head  = 0;
        fifo_count = 0;
        next_seq   = '0;
        is_stopped = 1'b0;
        errors     = 0;
        foreach (dly_valid[i]) dly_valid[i] = 1'b0;
    endfunction

    function int pending();
        return answers_due.size();
    endfunction

    // Updates the predicted stores for one accepted word and queues its answer.
    function void note_word(dtd_op_t op, logic [HANDLE_W-1:0] handle,
                            logic [DELAY_W-1:0] delay, logic [TIME_W-1:0] now);
        dispatch_answer_t ans;
        int               best;
        int               slot;
        int unsigned      tail;
        logic [TIME_W:0]  sum;
        ans.status = ST_ACCEPTED;
        ans.handle = '0;
        ans.sleep  = '0;
        case (op)
            OP_ADD_IMM: begin
                if (fifo_count >= IMMEDIATE_DEPTH_DEF) begin
                    ans.status = ST_FULL;
                end
                else begin
                    tail = (fifo_head + fifo_count) % IMMEDIATE_DEPTH_DEF;
                    fifo_handle[tail] = handle;
                    fifo_seq[tail]    = next_seq;
                    fifo_count++;
                    next_seq++;
                end
            end
            OP_ADD_DLY: begin
                slot = -1;
                for (int i = 0; i < DELAYED_DEPTH_DEF; i++) begin
                    if (slot < 0 && !dly_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    ans.status = ST_FULL;
                end
                else begin
                    sum = {1'b0, now} + {{(TIME_W-DELAY_W+1){1'b0}}, delay};
                    dly_expiry[slot] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                    dly_handle[slot] = handle;
                    dly_seq[slot]    = next_seq;
                    dly_valid[slot]  = 1'b1;
                    next_seq++;
                end
            end
            OP_STOP: begin
                is_stopped = 1'b1;
                ans.status = ST_STOPPED;
            end
            default: begin
                best = -1;
                for (int i = 0; i < DELAYED_DEPTH_DEF; i++) begin
                    if (dly_valid[i] && (best < 0 || dly_expiry[i] < dly_expiry[best] ||
                        (dly_expiry[i] == dly_expiry[best] && dly_seq[i] < dly_seq[best])))
                        best = i;
                end
                ans.status = ST_DISPATCHED;
                if (is_stopped) begin
                    ans.status = ST_STOPPED;
                end
                else if (best >= 0 && now >= dly_expiry[best]) begin
                    // An older immediate task still goes ahead of a due delayed one.
                    if (fifo_count > 0 && fifo_seq[fifo_head] < dly_seq[best]) begin
                        ans.handle = fifo_handle[fifo_head];
                        fifo_head  = (fifo_head + 1) % IMMEDIATE_DEPTH_DEF;
                        fifo_count--;
                    end
                    else begin
                        ans.handle      = dly_handle[best];
                        dly_valid[best] = 1'b0;
                    end
                end
                else if (fifo_count > 0) begin
                    ans.handle = fifo_handle[fifo_head];
                    fifo_head  = (fifo_head + 1) % IMMEDIATE_DEPTH_DEF;
                    fifo_count--;
                end
                else if (best >= 0) begin
                    ans.status = ST_TIMED;
                    ans.sleep  = dly_expiry[best] - now;
                end
                else begin
                    ans.status = ST_FOREVER;
                end
            end
        endcase
        answers_due.push_back(ans);
    endfunction

    function void check_result(logic [2:0] status, logic [HANDLE_W-1:0] handle,
                               logic [TIME_W-1:0] sleep);
        dispatch_answer_t want;
        if (answers_due.size() == 0) begin
            $display("%0t: unexpected answer word: status %0d handle %h sleep %h",
                     $time, status, handle, sleep);
            errors++;
            return;
        end
        want = answers_due.pop_front();
        if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
            errors++;
        end
        if (handle !== want.handle) begin
            $display("%0t: out_handle mismatch: expected %h, actual %h",
                     $time, want.handle, handle);
            errors++;
        end
        if (sleep !== want.sleep) begin
            $display("%0t: sleep_ms mismatch: expected %h, actual %h",
                     $time, want.sleep, sleep);
            errors++;
        end
    endfunction

endclass

module tb_delayed_task_dispatcher;

    // The run is bounded well above the slowest legal run: about 1650 words,
    // each with a full walk of the delayed set, plus sender gaps and receiver
    // stalls of 70 percent.
    localparam int LIMIT_CYCLES = 600000;
    localparam int WORDS_PER_PHASE = 400;
    // Longest stay of a word in the block before its answer loads, with no stall.
    localparam int TAIL_CYCLES = DELAYED_DEPTH_DEF + 8;

    // Traffic shapes. Fill segments mostly add, to one store or to both, and
    // drain segments mostly fetch; mixed segments interleave everything.
    typedef enum int {
        SEG_FILL_IMM,
        SEG_FILL_DLY,
        SEG_FILL_BOTH,
        SEG_DRAIN,
        SEG_MIXED
    } seg_kind_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic [HANDLE_W-1:0] task_handle;
    logic [DELAY_W-1:0]  delay_ms;
    logic [TIME_W-1:0]   now_ms;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [TIME_W-1:0]   sleep_ms;

    int                  idle_pct;
    int                  stall_pct;
    int                  cycle_count;
    logic [TIME_W-1:0]   clock_ms;
    dispatch_scoreboard  sb = new();

    delayed_task_dispatcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .task_handle (task_handle),
        .delay_ms    (delay_ms),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_handle  (out_handle),
        .sleep_ms    (sleep_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides afresh on every edge whether to hold off the
    // answer word, so stalls can land on any cycle of the block's work.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Both monitors sample at the rising edge, before any nonblocking update
    // of that edge, so they see exactly what the block saw.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(dtd_op_t'(operation), task_handle, delay_ms, now_ms);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, out_handle, sleep_ms);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Presents one word after a random idle gap and holds it, unchanged,
    // until the block takes it. The next call either drops valid or puts up
    // the following word, so valid gets one assignment per edge.
    task automatic send_word(input dtd_op_t op, input logic [HANDLE_W-1:0] handle,
                             input logic [DELAY_W-1:0] delay,
                             input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        task_handle <= handle;
        delay_ms    <= delay;
        now_ms      <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Holds the sender back until every predicted answer has been checked.
    // The first edge lets the monitor note the word accepted last.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Builds one word of the given traffic shape. Time mostly creeps forward
    // so that small delays expire a few words later; now and then it leaps
    // far ahead, jumps anywhere, or sits at the top of the 48-bit range.
    task automatic send_random_word(input seg_kind_t seg, input bit allow_stop);
        int                 r;
        int                 t;
        dtd_op_t            op;
        logic [DELAY_W-1:0] delay;
        r = $urandom_range(99);
        case (seg)
            SEG_FILL_IMM:  op = (r < 90) ? OP_ADD_IMM : OP_FETCH;
            SEG_FILL_DLY:  op = (r < 90) ? OP_ADD_DLY : OP_FETCH;
            SEG_FILL_BOTH: op = (r < 45) ? OP_ADD_IMM : (r < 90) ? OP_ADD_DLY : OP_FETCH;
            SEG_DRAIN:     op = (r < 85) ? OP_FETCH : (r < 93) ? OP_ADD_IMM : OP_ADD_DLY;
            default:       op = (r < 30) ? OP_ADD_IMM : (r < 60) ? OP_ADD_DLY : OP_FETCH;
        endcase
        if (allow_stop && $urandom_range(9) == 0)
            op = OP_STOP;

        t = $urandom_range(199);
        if (t == 0)
            clock_ms = {16'($urandom_range(65535)), 32'($urandom)};
        else if (t < 5)
            clock_ms = clock_ms + 48'h2_0000_0000;
        else if (t == 5)
            clock_ms = {TIME_W{1'b1}} - 48'($urandom_range(50));
        else
            clock_ms = clock_ms + 48'($urandom_range(3));

        r = $urandom_range(99);
        if (r < 60)
            delay = 32'($urandom_range(40));
        else if (r < 75)
            delay = '0;
        else if (r < 90)
            delay = 32'($urandom_range(1000));
        else
            delay = 32'($urandom);
        send_word(op, 16'($urandom), delay, clock_ms);
    endtask

    initial
    begin
        int        seg_left;
        seg_kind_t seg;
        int        phase;

        // Everything the block reads has a known value from time zero.
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_FETCH;
        task_handle = '0;
        delay_ms    = '0;
        now_ms      = '0;
        idle_pct    = 0;
        stall_pct   = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty fetch, a long timed wait, an immediate task
        // ahead of an undue delayed one, equal expiry broken by sequence, a due
        // delayed task beating a newer FIFO head, expiry saturation at the top of
        // the time range, and a sleep with bit 31 set.
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0000);
        send_word(OP_ADD_DLY, 16'hFFFF, 32'hFFFF_FFFF, 48'h0000_0000_0000);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0000);
        send_word(OP_ADD_IMM, 16'h0000, 32'h0000_0000, 48'h0000_0000_0000);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0000);
        send_word(OP_ADD_DLY, 16'h1111, 32'h0000_0000, 48'h0000_0000_0005);
        send_word(OP_ADD_DLY, 16'h2222, 32'h0000_0002, 48'h0000_0000_0003);
        send_word(OP_ADD_IMM, 16'h3333, 32'h0000_0000, 48'h0000_0000_0005);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0005);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0005);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0005);
        send_word(OP_ADD_DLY, 16'h4444, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_word(OP_ADD_DLY, 16'h5555, 32'h0000_0001, 48'hFFFF_FFFF_FFFE);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_word(OP_ADD_IMM, 16'hAAAA, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h0000_0000_0000);
        send_word(OP_ADD_DLY, 16'h5A5A, 32'h8000_0000, 48'h8000_0000_0000);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h7FFF_FFFF_FFFF);
        send_word(OP_FETCH,   16'h0000, 32'h0000_0000, 48'h8000_8000_0000);
        clock_ms = 48'h8000_8000_0000;

        // Random body in four idling phases: none, sender gaps, receiver
        // stalls, and both together. Each phase ends with the sender waiting
        // for every outstanding answer.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 70; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            seg_left = 0;
            seg = SEG_MIXED;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (seg_left == 0)
                begin
                    seg = seg_kind_t'($urandom_range(4));
                    seg_left = $urandom_range(8, 24);
                end
                send_random_word(seg, 1'b0);
                seg_left--;
            end
            wait_drained();
        end

        // Closing part: stop, a repeated stop, and adds that are still taken
        // or refused as full while every fetch now reports stopped.
        send_word(OP_STOP,  16'h0000, 32'h0000_0000, clock_ms);
        send_word(OP_FETCH, 16'h0000, 32'h0000_0000, clock_ms);
        send_word(OP_STOP,  16'h0000, 32'h0000_0000, clock_ms);
        for (int n = 0; n < 40; n++)
            send_random_word(seg_kind_t'($urandom_range(4)), 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dtd_pkg.sv
rtl/core/dtd_ram.sv
rtl/core/dtd_fifo.sv
rtl/core/dtd_delayed.sv
rtl/core/delayed_task_dispatcher.sv
dv/tb_delayed_task_dispatcher.sv
